// File: rtl/core/eptc_pkg.sv
// Shared types, constants and month table for the epoch-to-calendar converter.
`default_nettype none
package eptc_pkg;

  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned BaseYear   = 1970;
  localparam int unsigned FebShort   = 28;
  localparam int unsigned Months     = 12;
  localparam logic [31:0] LastSecond = 32'd4102444799;

  // Width of the packed result word on the output channel.
  localparam int unsigned OutWidth = 40;

  // Handshake status from the sequencer to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } eptc_stat_t;

  // One converted calendar result.
  typedef struct packed {
    logic [11:0] year_number;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } eptc_result_t;

  // Days in a month, month code 0 is January.
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon) inside
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:    len = leap ? 5'd29 : 5'(FebShort);
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/epoch_seconds_to_calendar_top.sv
// Top level: stream channels, offset register and output register around the sequencer.
//
// Converts seconds since 1970-01-01 00:00:00 into second, minute, hour, day of
// month, month and year, after adding a signed whole-hour offset. The sum is
// clamped to 1970-01-01 00:00:00 .. 2099-12-31 23:59:59.
// Input channel: in_tdata carries epoch_seconds; one word accepted on
// in_tvalid & in_tready. Output channel: one calendar word per input word.
// Configuration: cfg_wen writes cfg_wdata into the 5-bit signed hour offset,
// which resets to +1; write it only while no conversion is in flight.
// Days, hours and minutes come from restoring division on the shared
// subtract-compare unit; the year walk then runs one year per cycle through
// the same unit, followed by the month walk.
// One word is converted at a time; in_tready is high only while idle, so a
// new word is taken only once the previous conversion has finished. A
// finished result sits in the output register, and the next input word can
// be accepted while it waits. If the receiver stalls, the sequencer holds its
// next result until the output register frees.
// Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
`default_nettype none
module epoch_seconds_to_calendar_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
  // [25:22] month_number, [37:26] year_number, [39:38] zero
  output logic [eptc_pkg::OutWidth-1:0] out_tdata,
  input  wire logic        cfg_wen,
  input  wire logic [4:0]  cfg_wdata   // [4:0] utc_offset_hours, signed
);

  logic signed [4:0]                   offset_r;
  logic                                out_valid_r;
  logic [eptc_pkg::OutWidth-1:0]       out_data_r;
  logic                                start;
  logic                                res_free;
  eptc_pkg::eptc_stat_t                stat;
  eptc_pkg::eptc_result_t              result;

  assign in_tready = stat.idle;
  assign start     = in_tvalid && stat.idle;
  assign res_free  = !out_valid_r || out_tready;

  eptc_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .epoch_seconds    (in_tdata),
    .utc_offset_hours (offset_r),
    .res_free         (res_free),
    .stat             (stat),
    .result           (result)
  );

  // Hold the hour offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 5'sd1;
    end else if (cfg_wen) begin
      offset_r <= $signed(cfg_wdata);
    end
  end

  // Output register: load a finished word, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stat.done) begin
      out_data_r <= {2'b00, result.year_number, result.month_number,
                     result.day_of_month, result.hour, result.minute, result.second};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/core/eptc_core.sv
// Sequencer and shared subtract-compare unit that splits seconds into a calendar date.
`default_nettype none
module eptc_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [31:0]           epoch_seconds,
  input  wire logic signed [4:0]     utc_offset_hours,
  input  wire logic                  res_free,
  output eptc_pkg::eptc_stat_t       stat,
  output eptc_pkg::eptc_result_t     result
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIVD, S_DIVH, S_DIVM, S_YEAR, S_MON, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  mon_r, mon_nxt;

  logic               leap;
  logic [31:0]        operand;
  logic [32:0]        diff;
  logic               ge;
  logic signed [17:0] off_sec;
  logic signed [33:0] total;
  logic [31:0]        start_val;

  assign leap = (year_r[1:0] == 2'b00);

  // Apply the hour offset and clamp to the supported span
  assign off_sec = 18'(utc_offset_hours) * 18'sd3600;
  assign total   = $signed({2'b00, epoch_seconds}) + 34'(off_sec);
  always_comb begin
    if (total < 34'sd0) begin
      start_val = 32'd0;
    end else if (total > $signed({2'b00, eptc_pkg::LastSecond})) begin
      start_val = eptc_pkg::LastSecond;
    end else begin
      start_val = total[31:0];
    end
  end

  // Pick the subtrahend for the shared unit
  always_comb begin
    case (state_r)
      S_DIVD:  operand = 32'(eptc_pkg::SecPerDay) << bit_r;
      S_DIVH:  operand = 32'(eptc_pkg::SecPerHour) << bit_r;
      S_DIVM:  operand = 32'(eptc_pkg::SecPerMin) << bit_r;
      S_YEAR:  operand = leap ? 32'd366 : 32'd365;
      S_MON:   operand = 32'(eptc_pkg::month_days(mon_r, leap));
      default: operand = 32'd0;
    endcase
  end

  assign diff = {1'b0, acc_r} - {1'b0, operand};
  assign ge   = !diff[32];

  // Next-state and datapath sequencing
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    bit_nxt   = bit_r;
    days_nxt  = days_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          acc_nxt   = start_val;
          bit_nxt   = 4'd15;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (ge) acc_nxt = diff[31:0];
        days_nxt = {days_r[14:0], ge};
        bit_nxt  = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          bit_nxt   = 4'd4;
          state_nxt = S_DIVH;
        end
      end
      S_DIVH: begin
        if (ge) acc_nxt = diff[31:0];
        hour_nxt = {hour_r[3:0], ge};
        bit_nxt  = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          bit_nxt   = 4'd5;
          state_nxt = S_DIVM;
        end
      end
      S_DIVM: begin
        if (ge) acc_nxt = diff[31:0];
        min_nxt = {min_r[4:0], ge};
        bit_nxt = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          sec_nxt   = ge ? diff[5:0] : acc_r[5:0];
          acc_nxt   = {16'd0, days_r};
          year_nxt  = 12'(eptc_pkg::BaseYear);
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (ge) begin
          acc_nxt  = diff[31:0];
          year_nxt = year_r + 12'd1;
        end else begin
          mon_nxt   = 4'd0;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        if (ge && (mon_r != 4'(eptc_pkg::Months - 1))) begin
          acc_nxt = diff[31:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r  <= acc_nxt;
    bit_r  <= bit_nxt;
    days_r <= days_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE) && res_free;

  assign result.year_number  = year_r;
  assign result.month_number = mon_r + 4'd1;
  assign result.day_of_month = acc_r[4:0] + 5'd1;
  assign result.hour         = hour_r;
  assign result.minute       = min_r;
  assign result.second       = sec_r;

  // A new word only starts from idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE)) else $error("start outside idle");

  // Clamping keeps the year walk inside the supported span
  a_year_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR) |-> (year_r <= 12'd2099)) else $error("year walk overran");

  // Month walk never passes December
  a_mon_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MON) |-> (mon_r < 4'd12)) else $error("month walk overran");

  // Time of day is in range when the result is handed off
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (hour_r < 5'd24) && (min_r < 6'd60) && (sec_r < 6'd60))
    else $error("time of day out of range");

  // Day walk leaves fewer than one month of days
  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (acc_r < 32'd31)) else $error("day of month out of range");

endmodule
`default_nettype wire

// File: dv/eptc_calendar_checker.sv
// Checker for the epoch-to-calendar converter: predicts each date and compares the output words.
`default_nettype none
module eptc_calendar_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [eptc_pkg::OutWidth-1:0] out_tdata,
  input  wire logic        cfg_wen,
  input  wire logic [4:0]  cfg_wdata,
  output int               mismatch_count,
  output int               dates_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [4:0]        offset_hours;
  eptc_pkg::eptc_result_t   expected_dates[$];

  // Days in a month; month 0 is January, every fourth year is a leap year
  function automatic int unsigned month_length(int unsigned mon, int unsigned yr);
    case (mon)
      1:          return (yr % 4 == 0) ? 29 : eptc_pkg::FebShort;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // Apply the hour offset, clamp to the supported span, then walk years and months
  function automatic eptc_pkg::eptc_result_t calendar_of(logic [31:0] secs,
                                                         logic signed [4:0] offset);
    longint                 total;
    longint                 days;
    longint                 rem;
    int unsigned            yr;
    int unsigned            mon;
    longint                 span;
    eptc_pkg::eptc_result_t date;
    total = longint'(secs) + longint'(offset) * longint'(eptc_pkg::SecPerHour);
    if (total < 0) total = 0;
    if (total > longint'(eptc_pkg::LastSecond)) total = longint'(eptc_pkg::LastSecond);
    days = total / longint'(eptc_pkg::SecPerDay);
    rem  = total % longint'(eptc_pkg::SecPerDay);
    yr   = eptc_pkg::BaseYear;
    mon  = 0;
    forever begin
      span = (yr % 4 == 0) ? 366 : 365;
      if (days < span) break;
      days -= span;
      yr++;
    end
    forever begin
      span = month_length(mon, yr);
      if (days < span || mon + 1 >= eptc_pkg::Months) break;
      days -= span;
      mon++;
    end
    date.second       = 6'(rem % eptc_pkg::SecPerMin);
    date.minute       = 6'((rem / eptc_pkg::SecPerMin) % 60);
    date.hour         = 5'(rem / eptc_pkg::SecPerHour);
    date.day_of_month = 5'(days + 1);
    date.month_number = 4'(mon + 1);
    date.year_number  = 12'(yr);
    return date;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin
    mismatch_count = 0;
    dates_pending  = 0;
  end

  // Track the offset, queue a prediction per input word, compare per output word
  always @(posedge clk) begin
    eptc_pkg::eptc_result_t want;
    eptc_pkg::eptc_result_t got;
    if (!rst_n) begin
      offset_hours <= 5'sd1;
    end else begin
      if (cfg_wen) begin
        offset_hours <= cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        expected_dates.push_back(calendar_of(in_tdata, offset_hours));
      end
      if (out_tvalid && out_tready) begin
        got = eptc_pkg::eptc_result_t'(out_tdata[37:0]);
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected output word, expected none, actual %h", $time, out_tdata);
        end else begin
          want = expected_dates.pop_front();
          check_field("second", want.second, got.second);
          check_field("minute", want.minute, got.minute);
          check_field("hour", want.hour, got.hour);
          check_field("day_of_month", want.day_of_month, got.day_of_month);
          check_field("month_number", want.month_number, got.month_number);
          check_field("year_number", want.year_number, got.year_number);
        end
      end
    end
    dates_pending <= expected_dates.size();
  end

endmodule
`default_nettype wire

// File: dv/epoch_seconds_to_calendar_top_tb.sv
// Testbench top for the epoch-to-calendar converter: clock, reset, stimulus and verdict.
`default_nettype none
module epoch_seconds_to_calendar_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseCount   = 8;
  localparam int PhaseWords   = 156;
  localparam int QuietFirst   = 300;
  localparam int QuietLast    = 450;
  localparam int MidDrainWord = 700;
  localparam int RxQuietEnd   = 3000;
  localparam int RxHoldStart  = 30000;
  localparam int RxHoldLen    = 800;
  localparam int TailCycles   = 250;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [31:0]                   in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [eptc_pkg::OutWidth-1:0] out_tdata;
  logic                          cfg_wen;
  logic [4:0]                    cfg_wdata;
  int                            mismatch_count;
  int                            dates_pending;
  int                            words_sent;

  epoch_seconds_to_calendar_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  eptc_calendar_checker date_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .dates_pending  (dates_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one word, with random gaps outside the quiet window, and wait for accept
  task automatic send_seconds(logic [31:0] secs);
    while (!(words_sent >= QuietFirst && words_sent < QuietLast) &&
           $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Drop valid and hold until every predicted date has come out
  task automatic drain_dates();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (dates_pending != 0);
  endtask

  task automatic write_offset(logic [4:0] hours);
    cfg_wen   <= 1'b1;
    cfg_wdata <= hours;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Mix of edge-biased and uniform seconds, some beyond the supported span
  function automatic logic [31:0] random_seconds();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 200000);
      1:       return eptc_pkg::LastSecond - $urandom_range(0, 200000);
      2:       return $urandom;
      default: return $urandom_range(0, eptc_pkg::LastSecond);
    endcase
  endfunction

  // Receiver: no stalls at first, one long hold-off, random stalls otherwise
  initial begin
    int rx_cycle;
    out_tready <= 1'b0;
    rx_cycle = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      rx_cycle++;
      if (rx_cycle >= RxHoldStart && rx_cycle < RxHoldStart + RxHoldLen) begin
        out_tready <= 1'b0;
      end else if (rx_cycle < RxQuietEnd) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 19);
      end
      @(posedge clk);
    end
  end

  // Stimulus: directed words at the reset offset, then random phases per offset
  initial begin
    logic [31:0] directed_seconds[$];
    logic [4:0]  offset_plan[PhaseCount];
    words_sent = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    directed_seconds = '{32'd0, 32'd1, 32'd3599, 32'd3600, 32'd86399,
                         32'd31535999, 32'd36633599, 32'd36633600, 32'd68169600,
                         32'd951782400, eptc_pkg::LastSecond - 32'd3600,
                         eptc_pkg::LastSecond, eptc_pkg::LastSecond + 32'd1,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    offset_plan = '{5'b10000, 5'b01111, 5'b10100, 5'b01110, 5'b00000,
                    5'b11111, 5'(-5), 5'($urandom_range(0, 31))};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_seconds[i]) send_seconds(directed_seconds[i]);
    drain_dates();

    for (int p = 0; p < PhaseCount; p++) begin
      write_offset(offset_plan[p]);
      send_seconds(32'd0);
      send_seconds(eptc_pkg::LastSecond);
      for (int n = 0; n < PhaseWords; n++) begin
        if (words_sent == MidDrainWord) drain_dates();
        send_seconds(random_seconds());
      end
      drain_dates();
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && dates_pending == 0) begin
      $display("[epoch_seconds_to_calendar_top] OK");
    end else begin
      $display("[epoch_seconds_to_calendar_top] ERROR");
    end
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #20ms;
    $display("[epoch_seconds_to_calendar_top] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
